// ===== rtl/core/slscu_pkg.sv =====
`timescale 1ns / 1ps

package slscu_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned BYTES   = WORD_W / 8;

    typedef enum logic [3:0] {
        CMD_AND    = 4'd0,
        CMD_OR     = 4'd1,
        CMD_XOR    = 4'd2,
        CMD_EQUIV  = 4'd3,
        CMD_MERGE  = 4'd4,
        CMD_SHL    = 4'd5,
        CMD_SHR    = 4'd6,
        CMD_DSHL   = 4'd7,
        CMD_DSHR   = 4'd8,
        CMD_POPCNT = 4'd9,
        CMD_LZC    = 4'd10,
        CMD_MASK   = 4'd11
    } cmd_t;

    // which unit supplies the final word
    typedef enum logic [2:0] {
        RES_ZERO  = 3'd0,
        RES_LOGIC = 3'd1,
        RES_SHIFT = 3'd2,
        RES_POP   = 3'd3,
        RES_LZC   = 3'd4
    } res_kind_t;

    // stage load enables, shared by all pipeline sections
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } slscu_adv_t;

endpackage

// ===== rtl/core/slscu_shifter.sv =====
`timescale 1ns / 1ps

module slscu_shifter
    import slscu_pkg::*;
(
    input  logic                clk,
    input  slscu_adv_t          adv,
    input  logic [3:0]          command,
    input  logic [WORD_W-1:0]   operand_a,
    input  logic [WORD_W-1:0]   operand_b,
    input  logic [5:0]          shift_count,
    output logic [WORD_W-1:0]   shift_word
);

    localparam int unsigned PAIR_W   = 2 * WORD_W;
    localparam int unsigned COARSE_W = WORD_W + 7;

    logic [COARSE_W-1:0] coarse_reg;
    logic [COARSE_W-1:0] coarse_next;
    logic [2:0]          fine_reg;
    logic                left_reg;
    logic [WORD_W-1:0]   shift_reg;
    logic [WORD_W-1:0]   shift_next;

    logic                left;
    logic [WORD_W-1:0]   hi_word;
    logic [WORD_W-1:0]   lo_word;
    logic [PAIR_W-1:0]   pair;
    logic [PAIR_W-1:0]   pair_oriented;
    logic [PAIR_W-1:0]   pair_coarse;
    logic [COARSE_W-1:0] fine_shifted;

    // left shifts run as right shifts on the bit-reversed pair
    always_comb
    begin
        left    = (cmd_t'(command) == CMD_SHL) || (cmd_t'(command) == CMD_DSHL);
        hi_word = (cmd_t'(command) == CMD_SHR) ? '0 : operand_a;
        if (cmd_t'(command) == CMD_SHL)
        begin
            lo_word = '0;
        end
        else if (cmd_t'(command) == CMD_SHR)
        begin
            lo_word = operand_a;
        end
        else
        begin
            lo_word = operand_b;
        end
        pair = {hi_word, lo_word};
        for (int i = 0; i < PAIR_W; i++)
        begin
            pair_oriented[i] = left ? pair[PAIR_W-1-i] : pair[i];
        end
        pair_coarse = pair_oriented >> {shift_count[5:3], 3'b000};
        coarse_next = pair_coarse[COARSE_W-1:0];
    end

    always_comb
    begin
        fine_shifted = coarse_reg >> fine_reg;
        for (int i = 0; i < WORD_W; i++)
        begin
            shift_next[i] = left_reg ? fine_shifted[WORD_W-1-i] : fine_shifted[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load1)
        begin
            coarse_reg <= coarse_next;
            fine_reg   <= shift_count[2:0];
            left_reg   <= left;
        end
        if (adv.load2)
        begin
            shift_reg <= shift_next;
        end
    end

    assign shift_word = shift_reg;

endmodule

// ===== rtl/core/slscu_counter.sv =====
`timescale 1ns / 1ps

module slscu_counter
    import slscu_pkg::*;
(
    input  logic                 clk,
    input  slscu_adv_t           adv,
    input  logic [WORD_W-1:0]    operand_a,
    output logic [COUNT_W-1:0]   ones_total,
    output logic [COUNT_W-1:0]   lead_zeros
);

    logic [3:0]         byte_pop_reg  [BYTES];
    logic [3:0]         byte_pop_next [BYTES];
    logic [3:0]         byte_lz_reg   [BYTES];
    logic [3:0]         byte_lz_next  [BYTES];
    logic [5:0]         pop_lo_reg;
    logic [5:0]         pop_lo_next;
    logic [5:0]         pop_hi_reg;
    logic [5:0]         pop_hi_next;
    logic [COUNT_W-1:0] lz_reg;
    logic [COUNT_W-1:0] lz_next;

    // per-byte ones and leading zeros (8 means an empty byte)
    always_comb
    begin
        for (int k = 0; k < BYTES; k++)
        begin
            byte_pop_next[k] = '0;
            byte_lz_next[k]  = 4'd8;
            for (int i = 0; i < 8; i++)
            begin
                byte_pop_next[k] = byte_pop_next[k] + 4'(operand_a[8*k+i]);
                if (operand_a[8*k+i])
                begin
                    byte_lz_next[k] = 4'(7 - i);
                end
            end
        end
    end

    // half sums, and the highest non-empty byte wins
    always_comb
    begin
        pop_lo_next = '0;
        pop_hi_next = '0;
        for (int k = 0; k < BYTES / 2; k++)
        begin
            pop_lo_next = pop_lo_next + 6'(byte_pop_reg[k]);
            pop_hi_next = pop_hi_next + 6'(byte_pop_reg[k + BYTES / 2]);
        end
        lz_next = 7'(WORD_W);
        for (int k = 0; k < BYTES; k++)
        begin
            if (byte_lz_reg[k] != 4'd8)
            begin
                lz_next = {1'b0, 3'(BYTES - 1 - k), byte_lz_reg[k][2:0]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load1)
        begin
            byte_pop_reg <= byte_pop_next;
            byte_lz_reg  <= byte_lz_next;
        end
        if (adv.load2)
        begin
            pop_lo_reg <= pop_lo_next;
            pop_hi_reg <= pop_hi_next;
            lz_reg     <= lz_next;
        end
    end

    assign ones_total = 7'(pop_lo_reg) + 7'(pop_hi_reg);
    assign lead_zeros = lz_reg;

endmodule

// ===== rtl/core/scalar_logic_shift_count_unit.sv =====
`timescale 1ns / 1ps

// scalar logic, shift and count unit: 64-bit bitwise ops, merge, single and
// double logical shifts, population count, leading-zero count, low-ones mask
//
// input channel: in_valid / in_ready with command, operand_a, operand_b,
// mask_word and shift_count; one item in gives exactly one result_word out
// output channel: out_valid / out_ready with result_word
//
// pipeline: out_valid rises once an accepted item reaches the stage 3 output
// register, passing through these registered stages:
//   stage 1: bitwise ops, pair orientation and byte-step shift, byte counts
//   stage 2: bit-step shift, popcount half sums, leading-zero byte select
//   stage 3: final popcount add and result select into the output register
// throughput: an item per cycle unless stalled; shifter, counter fully staged
//
// reset (rst_n low, asynchronous) empties every stage; operand data is not
// cleared. when the receiver holds out_ready low, the output keeps its item
// and earlier stages keep filling bubbles; in_ready falls only once all
// three stages hold an item, so nothing is lost or duplicated

module scalar_logic_shift_count_unit
    import slscu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          command,
    input  logic [WORD_W-1:0]   operand_a,
    input  logic [WORD_W-1:0]   operand_b,
    input  logic [WORD_W-1:0]   mask_word,
    input  logic [5:0]          shift_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   result_word
);

    slscu_adv_t         adv;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;

    res_kind_t          kind1_reg;
    res_kind_t          kind1_next;
    res_kind_t          kind2_reg;
    logic [WORD_W-1:0]  logic1_reg;
    logic [WORD_W-1:0]  logic1_next;
    logic [WORD_W-1:0]  logic2_reg;
    logic [WORD_W-1:0]  result_word_reg;
    logic [WORD_W-1:0]  result_word_next;

    logic [WORD_W-1:0]  shift_word;
    logic [COUNT_W-1:0] ones_total;
    logic [COUNT_W-1:0] lead_zeros;

    // a stage loads when it is empty or its contents move on
    assign adv.load3 = !v3_reg || out_ready;
    assign adv.load2 = !v2_reg || adv.load3;
    assign adv.load1 = !v1_reg || adv.load2;
    assign in_ready  = adv.load1;

    // command decode and the bitwise results
    always_comb
    begin
        logic1_next = '0;
        unique case (cmd_t'(command))
            CMD_AND:
            begin
                kind1_next  = RES_LOGIC;
                logic1_next = operand_a & operand_b;
            end
            CMD_OR:
            begin
                kind1_next  = RES_LOGIC;
                logic1_next = operand_a | operand_b;
            end
            CMD_XOR:
            begin
                kind1_next  = RES_LOGIC;
                logic1_next = operand_a ^ operand_b;
            end
            CMD_EQUIV:
            begin
                kind1_next  = RES_LOGIC;
                logic1_next = ~(operand_a ^ operand_b);
            end
            CMD_MERGE:
            begin
                kind1_next  = RES_LOGIC;
                logic1_next = (operand_a & ~mask_word) | (operand_b & mask_word);
            end
            CMD_MASK:
            begin
                kind1_next  = RES_LOGIC;
                logic1_next = {WORD_W{1'b1}} >> shift_count;
            end
            CMD_SHL, CMD_SHR, CMD_DSHL, CMD_DSHR:
            begin
                kind1_next = RES_SHIFT;
            end
            CMD_POPCNT:
            begin
                kind1_next = RES_POP;
            end
            CMD_LZC:
            begin
                kind1_next = RES_LZC;
            end
            default:
            begin
                // unused codes give a zero word
                kind1_next = RES_ZERO;
            end
        endcase
    end

    slscu_shifter u_shifter (
        .clk         (clk),
        .adv         (adv),
        .command     (command),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .shift_count (shift_count),
        .shift_word  (shift_word)
    );

    slscu_counter u_counter (
        .clk        (clk),
        .adv        (adv),
        .operand_a  (operand_a),
        .ones_total (ones_total),
        .lead_zeros (lead_zeros)
    );

    // stage 3 select, counts zero-extended
    always_comb
    begin
        case (kind2_reg)
            RES_LOGIC: result_word_next = logic2_reg;
            RES_SHIFT: result_word_next = shift_word;
            RES_POP:   result_word_next = {{(WORD_W-COUNT_W){1'b0}}, ones_total};
            RES_LZC:   result_word_next = {{(WORD_W-COUNT_W){1'b0}}, lead_zeros};
            default:   result_word_next = '0;
        endcase
    end

    // valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv.load1)
            begin
                v1_reg <= in_valid;
            end
            if (adv.load2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv.load3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (adv.load1)
        begin
            kind1_reg  <= kind1_next;
            logic1_reg <= logic1_next;
        end
        if (adv.load2)
        begin
            kind2_reg  <= kind1_reg;
            logic2_reg <= logic1_reg;
        end
        if (adv.load3)
        begin
            result_word_reg <= result_word_next;
        end
    end

    assign out_valid   = v3_reg;
    assign result_word = result_word_reg;

    // an empty pipeline always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg) |-> in_ready)
        else $error("empty pipeline refuses an item");

    // an item in stage 1 that moves on lands in stage 2
    a_stage2_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv.load2) |=> v2_reg)
        else $error("item lost between stage 1 and stage 2");

    // a full pipeline with a stalled receiver must back-pressure the sender
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !out_ready) |-> !in_ready)
        else $error("full pipeline accepts an item under stall");

    // counts never exceed the word width
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> ((ones_total <= 7'(WORD_W)) && (lead_zeros <= 7'(WORD_W))))
        else $error("count beyond word width");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import slscu_pkg::*;

    // unused command codes, which must give a zero word
    localparam logic [3:0]        CMD_UNUSED_LO = 4'd12;
    localparam logic [3:0]        CMD_UNUSED_HI = 4'd15;
    localparam logic [WORD_W-1:0] ALL_ONES      = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] TOP_BIT       = {1'b1, {(WORD_W-1){1'b0}}};

    localparam int RANDOM_ITEMS = 1100;
    localparam int LONG_HOLD    = 48;    // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 8;     // pipeline is three deep, with margin
    localparam int IDLE_LIMIT   = 1000;  // cycles with no item moving on either side

    // one accepted item's expected result word, with its command for reporting
    typedef struct packed {
        logic [3:0]        code;
        logic [WORD_W-1:0] word;
    } pending_result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [3:0]        code;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] m;
        logic [5:0]        n;
        logic              typed;
        logic [WORD_W-1:0] word;
    } directed_row_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [3:0]        command     = '0;
    logic [WORD_W-1:0] operand_a   = '0;
    logic [WORD_W-1:0] operand_b   = '0;
    logic [WORD_W-1:0] mask_word   = '0;
    logic [5:0]        shift_count = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [WORD_W-1:0] result_word;

    pending_result_t expected_results[$];
    directed_row_t   directed_rows[$];

    int        mismatch_count   = 0;
    int        results_checked  = 0;
    int        items_sent       = 0;
    int        burst_left       = 0;
    int        hold_requests    = 0;
    int        idle_cycles      = 0;
    int        input_held_off   = 0;
    int        output_stalled   = 0;
    logic [15:0] codes_seen     = '0;

    scalar_logic_shift_count_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .mask_word   (mask_word),
        .shift_count (shift_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_word (result_word)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bit-exact model of the unit: one result word per command
    function automatic logic [WORD_W-1:0] logic_shift_count_word(
        input logic [3:0]        code,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] m,
        input logic [5:0]        n
    );
        logic [2*WORD_W-1:0] pair;
        logic [WORD_W-1:0]   w;
        int                  ones;
        int                  lead;
        w = '0;
        case (code)
            CMD_AND:   w = a & b;
            CMD_OR:    w = a | b;
            CMD_XOR:   w = a ^ b;
            CMD_EQUIV: w = ~(a ^ b);
            CMD_MERGE: w = (a & ~m) | (b & m);
            CMD_SHL:   w = a << n;
            CMD_SHR:   w = a >> n;
            CMD_DSHL:
            begin
                // upper word of the shifted pair; zero distance leaves a
                pair = {a, b} << n;
                w    = pair[2*WORD_W-1:WORD_W];
            end
            CMD_DSHR:
            begin
                // lower word of the shifted pair; zero distance leaves b
                pair = {a, b} >> n;
                w    = pair[WORD_W-1:0];
            end
            CMD_POPCNT:
            begin
                ones = 0;
                for (int i = 0; i < WORD_W; i++)
                    ones += a[i];
                w = WORD_W'(ones);
            end
            CMD_LZC:
            begin
                // walking upwards, the last set bit seen is the highest one
                lead = WORD_W;
                for (int i = 0; i < WORD_W; i++)
                    if (a[i])
                        lead = WORD_W - 1 - i;
                w = WORD_W'(lead);
            end
            CMD_MASK:  w = ALL_ONES >> n;
            default:   w = '0;
        endcase
        return w;
    endfunction

    // operand words of varied shape, so counts and shifts see every length
    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = ALL_ONES;
            2: w = TOP_BIT >> $urandom_range(0, WORD_W - 1);
            3: w = ~(TOP_BIT >> $urandom_range(0, WORD_W - 1));
            4: w = w >> $urandom_range(0, WORD_W - 1);
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] rand_count();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic add_row(
        input logic [3:0]        code,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] m,
        input logic [5:0]        n,
        input logic              typed,
        input logic [WORD_W-1:0] word
    );
        directed_row_t row;
        row = '{code: code, a: a, b: b, m: m, n: n, typed: typed, word: word};
        directed_rows.push_back(row);
    endtask

    // offer one item in the current burst, with a random gap between bursts;
    // the expectation is queued once the item is accepted
    task automatic send_item(
        input logic [3:0]        code,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] m,
        input logic [5:0]        n,
        input logic              typed,
        input logic [WORD_W-1:0] word
    );
        int              gap;
        pending_result_t entry;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= code;
        operand_a   <= a;
        operand_b   <= b;
        mask_word   <= m;
        shift_count <= n;
        do
            @(posedge clk);
        while (!in_ready);
        entry.code = code;
        entry.word = typed ? word : logic_shift_count_word(code, a, b, m, n);
        expected_results.push_back(entry);
        items_sent++;
        codes_seen[code] = 1'b1;
    endtask

    // stop offering and wait for every outstanding result to come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker: each result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        pending_result_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected", $time,
                         result_word);
                mismatch_count++;
            end
            else
            begin
                due = expected_results.pop_front();
                results_checked++;
                if (result_word !== due.word)
                begin
                    $display("%0t: command %0d result mismatch, expected %h, got %h",
                             $time, due.code, due.word, result_word);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on progress, plus stall counters for the summary
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                input_held_off++;
            if (out_valid && !out_ready)
                output_stalled++;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no item moved for %0d cycles, %0d results pending",
                         $time, idle_cycles, expected_results.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // receiver: a stall pattern of its own, changing mode every so often,
    // and a long hold-off whenever the stimulus asks for one
    initial
    begin : receiver
        int rx_mode;
        int rx_left;
        int rx_tick;
        int hold_served;
        rx_mode     = 0;
        rx_left     = 0;
        rx_tick     = 0;
        hold_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                // long hold-off: the pipeline fills and in_ready must drop
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_served++;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(20, 120);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    0: out_ready <= 1'b1;                              // never stalls
                    1: out_ready <= ($urandom_range(0, 3) != 0);       // light stalls
                    2: out_ready <= ((rx_tick % 5) < 3);               // periodic
                    default: out_ready <= ($urandom_range(0, 3) == 0); // heavy stalls
                endcase
            end
        end
    end

    // stimulus: reset, directed table, random items, then drain and report
    initial
    begin : stimulus
        logic [3:0] code;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table: extremes and special cases; zero rows fall back
        // to the model of the unit
        add_row(CMD_AND, ALL_ONES, ALL_ONES, 64'h5a5a_5a5a_5a5a_5a5a, 6'd17, 1'b1, ALL_ONES);
        add_row(CMD_OR, '0, '0, ALL_ONES, 6'd63, 1'b1, '0);
        add_row(CMD_XOR, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, '0, 6'd5,
                1'b0, '0);
        add_row(CMD_EQUIV, '0, '0, ALL_ONES, 6'd1, 1'b1, ALL_ONES);
        // merge: mask bit set takes b, clear takes a
        add_row(CMD_MERGE, '0, ALL_ONES, 64'hf0f0_0f0f_aaaa_5555, 6'd0, 1'b1,
                64'hf0f0_0f0f_aaaa_5555);
        add_row(CMD_MERGE, ALL_ONES, '0, '0, 6'd9, 1'b1, ALL_ONES);
        add_row(CMD_MERGE, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                64'h00ff_ff00_0f0f_f0f0, 6'd33, 1'b0, '0);
        // zero shift distances leave the word untouched
        add_row(CMD_SHL, 64'hdead_beef_0000_0001, ALL_ONES, ALL_ONES, 6'd0, 1'b1,
                64'hdead_beef_0000_0001);
        add_row(CMD_SHL, 64'd1, '0, '0, 6'd63, 1'b1, TOP_BIT);
        add_row(CMD_SHR, TOP_BIT, ALL_ONES, '0, 6'd0, 1'b1, TOP_BIT);
        add_row(CMD_SHR, ALL_ONES, '0, ALL_ONES, 6'd63, 1'b1, 64'd1);
        add_row(CMD_DSHL, 64'h1111_2222_3333_4444, TOP_BIT, '0, 6'd0, 1'b1,
                64'h1111_2222_3333_4444);
        add_row(CMD_DSHL, '0, ALL_ONES, '0, 6'd63, 1'b0, '0);
        add_row(CMD_DSHL, ALL_ONES, '0, ALL_ONES, 6'd32, 1'b0, '0);
        add_row(CMD_DSHR, 64'd1, 64'd2, ALL_ONES, 6'd0, 1'b1, 64'd2);
        add_row(CMD_DSHR, ALL_ONES, '0, '0, 6'd1, 1'b0, '0);
        add_row(CMD_DSHR, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, '0, 6'd63,
                1'b0, '0);
        add_row(CMD_POPCNT, ALL_ONES, 64'h1234, ALL_ONES, 6'd7, 1'b1, 64'd64);
        add_row(CMD_POPCNT, '0, ALL_ONES, '0, 6'd63, 1'b1, '0);
        // leading zeros of a zero word count the whole width
        add_row(CMD_LZC, '0, ALL_ONES, ALL_ONES, 6'd63, 1'b1, 64'd64);
        add_row(CMD_LZC, 64'd1, '0, '0, 6'd0, 1'b1, 64'd63);
        add_row(CMD_LZC, ALL_ONES, '0, '0, 6'd0, 1'b1, '0);
        // ones mask: zero count gives all ones
        add_row(CMD_MASK, 64'h8765_4321_0fed_cba9, ALL_ONES, ALL_ONES, 6'd0, 1'b1, ALL_ONES);
        add_row(CMD_MASK, ALL_ONES, ALL_ONES, '0, 6'd63, 1'b1, 64'd1);
        // unused codes return zero whatever the operands
        add_row(CMD_UNUSED_LO, ALL_ONES, ALL_ONES, ALL_ONES, 6'd63, 1'b1, '0);
        add_row(CMD_UNUSED_HI, ALL_ONES, 64'h0123_4567_89ab_cdef, ALL_ONES, 6'd1, 1'b1, '0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].code, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].m, directed_rows[i].n, directed_rows[i].typed,
                      directed_rows[i].word);
        wait_drained();

        // random part: mostly valid commands, some unused codes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 350)
            begin
                // long receiver hold-off while the sender keeps offering items
                hold_requests++;
                burst_left = 150;
            end
            if (i == 700)
                wait_drained();
            if ($urandom_range(0, 9) == 0)
                code = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            else
                code = 4'($urandom_range(int'(CMD_AND), int'(CMD_MASK)));
            send_item(code, rand_word(), rand_word(), rand_word(), rand_count(), 1'b0, '0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d items (%0d directed), %0d results checked, %0d of 16 codes",
                 items_sent, directed_rows.size(), results_checked, $countones(codes_seen));
        $display("summary: input held off %0d cycles, output stalled %0d cycles",
                 input_held_off, output_stalled);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/slscu_pkg.sv
rtl/core/slscu_shifter.sv
rtl/core/slscu_counter.sv
rtl/core/scalar_logic_shift_count_unit.sv
tb/sv/tb_top.sv
